// ===== design/pvm_pkg.sv =====
`default_nettype none

package pvm_pkg;

   localparam int VOICES       = 8;
   localparam int PHASE_BITS   = 24;
   localparam int SINE_ENTRIES = 256;

   localparam int SINE_BITS   = $clog2(SINE_ENTRIES);
   localparam int QUARTER     = (SINE_ENTRIES / 4 > 0) ? SINE_ENTRIES / 4 : 1;
   localparam int SINE_W      = 16;
   localparam int SINE_FRAC   = 15;

   localparam int MODE_W      = 2;
   localparam int FREQ_W      = 16;
   localparam int SEL_W       = 3;
   localparam int SAMPLE_W    = 8;
   localparam int VOL_W       = 7;
   localparam int SPH_W       = 18;
   localparam int STEP_SHIFT  = 8;
   localparam int STEP_PROD_W = FREQ_W + SPH_W;

   localparam int VIDX_W      = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int COUNT_W     = $clog2(VOICES + 1);
   localparam int PROD_W      = VOL_W + 1 + SINE_W;
   localparam int CNT_MAX     = (VOICES > VOL_W) ? VOICES : VOL_W;
   localparam int CNT_W       = $clog2(CNT_MAX);
   localparam int DRAIN       = 2;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = SPH_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_VOLUME      = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_PER_HZ = 1'd1;

   localparam logic [VOL_W-1:0] VOLUME_RESET      = 7'd64;
   localparam logic [SPH_W-1:0] STEP_PER_HZ_RESET = 18'd194783;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MID = 8'd128;

   localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_START   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RETRIG  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_STOP    = 2'd3;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

   typedef logic signed [SINE_W-1:0] sine_tab_type [SINE_ENTRIES];

   typedef struct packed {
      logic              accept;
      logic              div_step;
      logic              issue;
      logic [VIDX_W-1:0] idx;
      logic              load_out;
   } pvm_cmd_type;

   // 32767*sin(pi/2 * m / QUARTER), taylor series in q30
   function automatic logic [SINE_W-1:0] quarter_sine(input logic [63:0] m);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      x  = (HALF_PI_Q30 * m) / QUARTER;
      x2 = (x * x) >> 30;
      t  = ONE_Q30 - x2 / 64'd110;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      s  = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
      if (s > 64'd32767) begin
         s = 64'd32767;
      end
      return s[SINE_W-1:0];
   endfunction

   function automatic sine_tab_type build_sine_tab();
      sine_tab_type tab;
      int           quad;
      int           r;
      logic [SINE_W-1:0] v;
      for (int k = 0; k < SINE_ENTRIES; k++) begin
         quad = (k / QUARTER) % 4;
         r    = k % QUARTER;
         if (quad == 0 || quad == 2) begin
            v = quarter_sine(64'(r));
         end else begin
            v = quarter_sine(64'(QUARTER - r));
         end
         tab[k] = (quad >= 2) ? -$signed(v) : $signed(v);
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

// ===== design/pvm_req_if.sv =====
`default_nettype none

interface pvm_req_if;
   import pvm_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [FREQ_W-1:0] freq_hz;
   logic [SEL_W-1:0]  voice_sel;

   modport source (output valid, output mode, output freq_hz, output voice_sel,
                   input ready);
   modport sink   (input valid, input mode, input freq_hz, input voice_sel,
                   output ready);
endinterface

`default_nettype wire

// ===== design/pvm_rsp_if.sv =====
`default_nettype none

interface pvm_rsp_if;
   import pvm_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic [SEL_W-1:0]    voice_out;
   logic                accepted;

   modport source (output valid, output sample, output voice_out, output accepted,
                   input ready);
   modport sink   (input valid, input sample, input voice_out, input accepted,
                   output ready);
endinterface

`default_nettype wire

// ===== design/polyphonic_sine_voice_mixer.sv =====
// tick: 7 divide steps for the per-voice amplitude, one cycle per voice through the
// shared multiplier, then a drain, then the result is loaded into the output register
// start, retrigger, stop: skip the divide, mix and drain; the result is loaded directly
// one word in flight; a new word is taken once the result is in the output register
// synchronous active-high reset clears all voices and restores volume and step per hertz
`default_nettype none

module polyphonic_sine_voice_mixer (
   input  wire logic                            clock,
   input  wire logic                            reset,
   pvm_req_if.sink                              req_chan,
   pvm_rsp_if.source                            rsp_chan,
   input  wire logic                            csr_we,
   input  wire logic [pvm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pvm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import pvm_pkg::*;

   pvm_cmd_type cmd;
   logic        req_ready;
   logic        rsp_valid;

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

   pvm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   pvm_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_mode      (req_chan.mode),
      .req_freq_hz   (req_chan.freq_hz),
      .req_voice_sel (req_chan.voice_sel),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_sample    (rsp_chan.sample),
      .rsp_voice_out (rsp_chan.voice_out),
      .rsp_accepted  (rsp_chan.accepted)
   );

endmodule

`default_nettype wire

// ===== design/pvm_ctrl.sv =====
`default_nettype none

module pvm_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic [pvm_pkg::MODE_W-1:0] req_mode,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output pvm_pkg::pvm_cmd_type           cmd
);
   import pvm_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_MIX,
      S_DRAIN,
      S_SEND
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             rsp_valid_ff;
   logic             accept;
   logic             out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.accept   = accept;
      cmd.div_step = (state_ff == S_DIV);
      cmd.issue    = (state_ff == S_MIX);
      cmd.idx      = cnt_ff[VIDX_W-1:0];
      cmd.load_out = (state_ff == S_SEND) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               cnt_ff <= '0;
               if (accept) begin
                  state_ff <= (req_mode == MODE_TICK) ? S_DIV : S_SEND;
               end
            end
            S_DIV: begin
               if (cnt_ff == CNT_W'(VOL_W - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= S_MIX;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end
            S_MIX: begin
               if (cnt_ff == CNT_W'(VOICES - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= S_DRAIN;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end
            S_DRAIN: begin
               if (cnt_ff == CNT_W'(DRAIN - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= S_SEND;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end
            S_SEND: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/pvm_datapath.sv =====
`default_nettype none

module pvm_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire pvm_pkg::pvm_cmd_type           cmd,
   input  wire logic [pvm_pkg::MODE_W-1:0]     req_mode,
   input  wire logic [pvm_pkg::FREQ_W-1:0]     req_freq_hz,
   input  wire logic [pvm_pkg::SEL_W-1:0]      req_voice_sel,
   input  wire logic                           csr_we,
   input  wire logic [pvm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pvm_pkg::CSR_DATA_W-1:0] csr_data,
   output logic [pvm_pkg::SAMPLE_W-1:0]        rsp_sample,
   output logic [pvm_pkg::SEL_W-1:0]           rsp_voice_out,
   output logic                                rsp_accepted
);
   import pvm_pkg::*;

   logic [VOL_W-1:0]      volume_ff;
   logic [SPH_W-1:0]      sph_ff;

   logic [PHASE_BITS-1:0] phase_ff [VOICES];
   logic [PHASE_BITS-1:0] phase_in [VOICES];
   logic [PHASE_BITS-1:0] step_ff  [VOICES];
   logic [PHASE_BITS-1:0] step_in  [VOICES];
   logic [VOICES-1:0]     busy_ff, busy_in;
   logic [COUNT_W-1:0]    count_ff, count_in;

   logic [MODE_W-1:0]     mode_ff;
   logic [SEL_W-1:0]      res_voice_ff, res_voice_in;
   logic                  res_acc_ff, res_acc_in;

   logic [VOL_W-1:0]      num_ff, num_in;
   logic [VOL_W-1:0]      quo_ff, quo_in;
   logic [COUNT_W-1:0]    rem_ff, rem_in;
   logic [COUNT_W:0]      div_trial;
   logic [VOL_W-1:0]      amp;

   logic signed [SINE_W-1:0] sine_ff;
   logic                     v1_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     v2_ff;
   logic signed [PROD_W-1:0] prod_biased;
   logic signed [PROD_W-1:0] term;
   logic [SAMPLE_W-1:0]      sum_ff, sum_in;

   logic [STEP_PROD_W-1:0]   step_prod;
   logic [VIDX_W-1:0]        sel_idx;
   logic                     sel_ok;
   logic                     found;

   logic [SAMPLE_W-1:0]      out_sample_ff;
   logic [SEL_W-1:0]         out_voice_ff;
   logic                     out_acc_ff;

   assign step_prod = req_freq_hz * sph_ff;
   assign sel_idx   = req_voice_sel[VIDX_W-1:0];
   assign sel_ok    = (32'(req_voice_sel) < VOICES) && busy_ff[sel_idx];

   // one quotient bit per step
   assign div_trial = {rem_ff, num_ff[VOL_W-1]};
   assign amp       = (count_ff == '0) ? '0 : quo_ff;

   // truncate toward zero
   assign prod_biased = prod_ff + (prod_ff[PROD_W-1] ?
                        PROD_W'((1 << SINE_FRAC) - 1) : PROD_W'(0));
   assign term        = prod_biased >>> SINE_FRAC;

   always_comb begin
      phase_in     = phase_ff;
      step_in      = step_ff;
      busy_in      = busy_ff;
      count_in     = count_ff;
      res_voice_in = res_voice_ff;
      res_acc_in   = res_acc_ff;
      num_in       = num_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      sum_in       = sum_ff;
      found        = 1'b0;

      if (cmd.accept) begin
         res_voice_in = '0;
         res_acc_in   = 1'b0;
         case (req_mode)
            MODE_TICK: begin
               res_acc_in = 1'b1;
               num_in     = volume_ff;
               quo_in     = '0;
               rem_in     = '0;
               sum_in     = SAMPLE_MID;
            end
            MODE_START: begin
               for (int i = 0; i < VOICES; i++) begin
                  if (!found && !busy_ff[i]) begin
                     found        = 1'b1;
                     busy_in[i]   = 1'b1;
                     phase_in[i]  = '0;
                     step_in[i]   = PHASE_BITS'(step_prod >> STEP_SHIFT);
                     count_in     = count_ff + COUNT_W'(1);
                     res_voice_in = SEL_W'(i);
                     res_acc_in   = 1'b1;
                  end
               end
            end
            MODE_RETRIG: begin
               if (sel_ok) begin
                  phase_in[sel_idx] = '0;
                  res_acc_in        = 1'b1;
               end
            end
            MODE_STOP: begin
               if (sel_ok) begin
                  busy_in[sel_idx] = 1'b0;
                  if (count_ff != '0) begin
                     count_in = count_ff - COUNT_W'(1);
                  end
                  res_acc_in = 1'b1;
               end
            end
            default: begin
               res_acc_in = 1'b0;
            end
         endcase
      end

      if (cmd.div_step) begin
         num_in = num_ff << 1;
         if (div_trial >= {1'b0, count_ff}) begin
            rem_in = COUNT_W'(div_trial - {1'b0, count_ff});
            quo_in = {quo_ff[VOL_W-2:0], 1'b1};
         end else begin
            rem_in = div_trial[COUNT_W-1:0];
            quo_in = {quo_ff[VOL_W-2:0], 1'b0};
         end
      end

      if (cmd.issue && busy_ff[cmd.idx]) begin
         phase_in[cmd.idx] = phase_ff[cmd.idx] + step_ff[cmd.idx];
      end

      if (v2_ff) begin
         sum_in = sum_ff + term[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff <= VOLUME_RESET;
         sph_ff    <= STEP_PER_HZ_RESET;
         for (int i = 0; i < VOICES; i++) begin
            phase_ff[i] <= '0;
            step_ff[i]  <= '0;
         end
         busy_ff  <= '0;
         count_ff <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_VOLUME) begin
            volume_ff <= csr_data[VOL_W-1:0];
         end
         if (csr_we && csr_index == CSR_STEP_PER_HZ) begin
            sph_ff <= csr_data[SPH_W-1:0];
         end
         phase_ff <= phase_in;
         step_ff  <= step_in;
         busy_ff  <= busy_in;
         count_ff <= count_in;
         v1_ff    <= cmd.issue && busy_ff[cmd.idx];
         v2_ff    <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff <= req_mode;
      end
      res_voice_ff <= res_voice_in;
      res_acc_ff   <= res_acc_in;
      num_ff       <= num_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      sum_ff       <= sum_in;
      sine_ff      <= SINE_TAB[phase_ff[cmd.idx][PHASE_BITS-1 -: SINE_BITS]];
      prod_ff      <= $signed({1'b0, amp}) * sine_ff;
      if (cmd.load_out) begin
         out_sample_ff <= (mode_ff == MODE_TICK) ? sum_ff : '0;
         out_voice_ff  <= res_voice_ff;
         out_acc_ff    <= res_acc_ff;
      end
   end

   assign rsp_sample    = out_sample_ff;
   assign rsp_voice_out = out_voice_ff;
   assign rsp_accepted  = out_acc_ff;

endmodule

`default_nettype wire

// ===== design/pvm_checker.sv =====
`default_nettype none

module pvm_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [pvm_pkg::SAMPLE_W-1:0]  rsp_sample,
   input wire logic [pvm_pkg::SEL_W-1:0]     rsp_voice_out,
   input wire logic                          rsp_accepted
);
   import pvm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped before it was taken");

   a_sample_implies_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample != '0 |-> rsp_accepted)
      else $error("nonzero sample without accepted");

   a_voice_implies_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_voice_out != '0 |-> rsp_accepted && rsp_sample == '0)
      else $error("voice reported on a word that is not a successful start");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind polyphonic_sine_voice_mixer pvm_checker u_pvm_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_sample    (rsp_chan.sample),
   .rsp_voice_out (rsp_chan.voice_out),
   .rsp_accepted  (rsp_chan.accepted)
);

`default_nettype wire
